FILE: hdl/assert_macros.svh
// Assertion macros shared by the calendar clock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while the synchronous reset is held.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: hdl/bcc_pkg.sv
// Types, constants and calendar helper functions for the BCD calendar clock.
package bcc_pkg;

    localparam logic [6:0] C_CENTURY_MAX   = 7'd99;
    localparam logic [6:0] C_YEAR_MAX      = 7'd99;
    localparam logic [3:0] C_MONTH_MAX     = 4'd12;
    localparam logic [4:0] C_HOUR_MAX      = 5'd23;
    localparam logic [5:0] C_MINSEC_MAX    = 6'd59;
    localparam logic [6:0] C_HUNDREDTH_MAX = 7'd99;

    localparam logic [6:0] C_RST_CENTURY = 7'd20;

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } t_mode;

    typedef struct packed {
        logic       mode;
        logic [6:0] load_century;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } t_bcc_in;

    typedef struct packed {
        logic [7:0]  century_bcd;
        logic [7:0]  year_bcd;
        logic [4:0]  month_bcd;
        logic [5:0]  day_bcd;
        logic [5:0]  hour_bcd;
        logic [6:0]  minute_bcd;
        logic [6:0]  second_bcd;
        logic [7:0]  hundredth_bcd;
        logic [63:0] elapsed_ticks;
    } t_bcc_out;

    typedef struct packed {
        logic [6:0]  century_count;
        logic [6:0]  year_count;
        logic [3:0]  month_count;
        logic [4:0]  day_count;
        logic [4:0]  hour_count;
        logic [5:0]  minute_count;
        logic [5:0]  second_count;
        logic [6:0]  hundredth_count;
        logic [63:0] tick_total;
    } t_cal_state;

    // With century and year both below 100, the full year is a multiple of 4
    // exactly when the year is, and of 400 exactly when the year is zero and
    // the century is a multiple of 4.
    function automatic logic is_leap(input logic [6:0] cen, input logic [6:0] yr);
        logic leap;
        if (yr == 7'd0) begin
            leap = (cen[1:0] == 2'd0);
        end else begin
            leap = (yr[1:0] == 2'd0);
        end
        return leap;
    endfunction

    // Length of a month; a month code outside 1 to 12 is taken as January.
    function automatic logic [4:0] days_in(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // Two packed BCD digits of a value below 100; the tens digit comes from
    // a multiply by the reciprocal of ten.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - (7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

FILE: hdl/bcc_update.sv
// Next calendar state for one request: a load with saturation or a tick with carries.
module bcc_update (
    input  bcc_pkg::t_cal_state i_state,
    input  bcc_pkg::t_bcc_in    i_item,
    input  logic                i_run_enable,
    output bcc_pkg::t_cal_state o_state
);

    logic [6:0] w_cen;
    logic [6:0] w_yr;
    logic [3:0] w_mon;
    logic [4:0] w_day_max;
    logic [4:0] w_dim;
    logic       w_h_wrap;
    logic       w_s_wrap;
    logic       w_m_wrap;
    logic       w_hr_wrap;
    logic       w_d_wrap;
    logic       w_mo_wrap;
    logic       w_y_wrap;

    // Load path: each field saturates; the day is clamped to the loaded month.
    always_comb begin
        w_cen = (i_item.load_century > bcc_pkg::C_CENTURY_MAX) ?
                bcc_pkg::C_CENTURY_MAX : i_item.load_century;
        w_yr  = (i_item.load_year > bcc_pkg::C_YEAR_MAX) ?
                bcc_pkg::C_YEAR_MAX : i_item.load_year;
        if (i_item.load_month == 4'd0) begin
            w_mon = 4'd1;
        end else if (i_item.load_month > bcc_pkg::C_MONTH_MAX) begin
            w_mon = bcc_pkg::C_MONTH_MAX;
        end else begin
            w_mon = i_item.load_month;
        end
        w_day_max = bcc_pkg::days_in(w_mon, bcc_pkg::is_leap(w_cen, w_yr));
    end

    // Tick path: a ripple of wrap conditions from hundredths up to centuries.
    always_comb begin
        w_dim = bcc_pkg::days_in(i_state.month_count,
                                 bcc_pkg::is_leap(i_state.century_count, i_state.year_count));
        w_h_wrap  = (i_state.hundredth_count >= bcc_pkg::C_HUNDREDTH_MAX);
        w_s_wrap  = w_h_wrap && (i_state.second_count >= bcc_pkg::C_MINSEC_MAX);
        w_m_wrap  = w_s_wrap && (i_state.minute_count >= bcc_pkg::C_MINSEC_MAX);
        w_hr_wrap = w_m_wrap && (i_state.hour_count >= bcc_pkg::C_HOUR_MAX);
        w_d_wrap  = w_hr_wrap && (i_state.day_count >= w_dim);
        w_mo_wrap = w_d_wrap && (i_state.month_count >= bcc_pkg::C_MONTH_MAX);
        w_y_wrap  = w_mo_wrap && (i_state.year_count >= bcc_pkg::C_YEAR_MAX);
    end

    always_comb begin
        o_state = i_state;
        if (i_item.mode == bcc_pkg::MODE_LOAD) begin
            o_state.century_count   = w_cen;
            o_state.year_count      = w_yr;
            o_state.month_count     = w_mon;
            if (i_item.load_day == 5'd0) begin
                o_state.day_count = 5'd1;
            end else if (i_item.load_day > w_day_max) begin
                o_state.day_count = w_day_max;
            end else begin
                o_state.day_count = i_item.load_day;
            end
            o_state.hour_count      = (i_item.load_hour > bcc_pkg::C_HOUR_MAX) ?
                                      bcc_pkg::C_HOUR_MAX : i_item.load_hour;
            o_state.minute_count    = (i_item.load_minute > bcc_pkg::C_MINSEC_MAX) ?
                                      bcc_pkg::C_MINSEC_MAX : i_item.load_minute;
            o_state.second_count    = (i_item.load_second > bcc_pkg::C_MINSEC_MAX) ?
                                      bcc_pkg::C_MINSEC_MAX : i_item.load_second;
            o_state.hundredth_count = 7'd0;
        end else if (i_run_enable) begin
            o_state.tick_total      = i_state.tick_total + 64'd1;
            o_state.hundredth_count = w_h_wrap ? 7'd0 : i_state.hundredth_count + 7'd1;
            if (w_h_wrap) begin
                o_state.second_count = w_s_wrap ? 6'd0 : i_state.second_count + 6'd1;
            end
            if (w_s_wrap) begin
                o_state.minute_count = w_m_wrap ? 6'd0 : i_state.minute_count + 6'd1;
            end
            if (w_m_wrap) begin
                o_state.hour_count = w_hr_wrap ? 5'd0 : i_state.hour_count + 5'd1;
            end
            if (w_hr_wrap) begin
                o_state.day_count = w_d_wrap ? 5'd1 : i_state.day_count + 5'd1;
            end
            if (w_d_wrap) begin
                o_state.month_count = w_mo_wrap ? 4'd1 : i_state.month_count + 4'd1;
            end
            if (w_mo_wrap) begin
                o_state.year_count = w_y_wrap ? 7'd0 : i_state.year_count + 7'd1;
            end
            if (w_y_wrap) begin
                o_state.century_count = (i_state.century_count >= bcc_pkg::C_CENTURY_MAX) ?
                                        7'd0 : i_state.century_count + 7'd1;
            end
        end
    end

endmodule

FILE: hdl/bcc_result_fmt.sv
// Converts the binary calendar counters into the packed BCD result.
module bcc_result_fmt (
    input  bcc_pkg::t_cal_state i_state,
    output bcc_pkg::t_bcc_out   o_result
);

    logic [7:0] w_month;
    logic [7:0] w_day;
    logic [7:0] w_hour;
    logic [7:0] w_minute;
    logic [7:0] w_second;

    always_comb begin
        w_month  = bcc_pkg::to_bcd(7'(i_state.month_count));
        w_day    = bcc_pkg::to_bcd(7'(i_state.day_count));
        w_hour   = bcc_pkg::to_bcd(7'(i_state.hour_count));
        w_minute = bcc_pkg::to_bcd(7'(i_state.minute_count));
        w_second = bcc_pkg::to_bcd(7'(i_state.second_count));

        o_result.century_bcd   = bcc_pkg::to_bcd(i_state.century_count);
        o_result.year_bcd      = bcc_pkg::to_bcd(i_state.year_count);
        o_result.month_bcd     = w_month[4:0];
        o_result.day_bcd       = w_day[5:0];
        o_result.hour_bcd      = w_hour[5:0];
        o_result.minute_bcd    = w_minute[6:0];
        o_result.second_bcd    = w_second[6:0];
        o_result.hundredth_bcd = bcc_pkg::to_bcd(i_state.hundredth_count);
        o_result.elapsed_ticks = i_state.tick_total;
    end

endmodule

FILE: hdl/bcd_calendar_clock.sv
// BCD calendar clock top level: request register, calendar state and result register.
//
// The clock takes one request per cycle while its input is not stalled and returns one
// result per request. A request first lands in the input register; when it can move on
// to a free or emptying result register, the calendar update (a load with
// saturation, or a 10 ms tick carried through seconds, minutes, hours, days of the
// month, months, years and centuries) and the BCD formatting are done in one pass
// and written together into the calendar state and the result register. A stall on
// the output holds both registers; the input register keeps taking requests as
// long as its contents can move on. After reset the calendar reads 1 January of
// century 20, year 0, midnight, with the tick count at zero and ticks enabled.
// run_enable may be written at any time the clock has no request in flight.
`include "assert_macros.svh"

module bcd_calendar_clock (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bcc_pkg::t_bcc_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bcc_pkg::t_bcc_out o_out_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    logic                r_in_valid;
    bcc_pkg::t_bcc_in    r_in;
    logic                r_out_valid;
    bcc_pkg::t_bcc_out   r_out;
    bcc_pkg::t_cal_state r_state;
    bcc_pkg::t_cal_state n_state;
    bcc_pkg::t_bcc_out   n_out;
    logic                r_run_enable;
    logic                w_accept;
    logic                w_move;

    // A request moves to the result register when that register is free or
    // is being emptied in the same cycle.
    assign w_move      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_move;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_result = r_out;
    assign o_cfg_ready = 1'b1;

    bcc_update u_update (
        .i_state      (r_state),
        .i_item       (r_in),
        .i_run_enable (r_run_enable),
        .o_state      (n_state)
    );

    bcc_result_fmt u_fmt (
        .i_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_run_enable <= 1'b1;
            r_state      <= '{century_count: bcc_pkg::C_RST_CENTURY, year_count: 7'd0,
                              month_count: 4'd1, day_count: 5'd1, hour_count: 5'd0,
                              minute_count: 6'd0, second_count: 6'd0,
                              hundredth_count: 7'd0, tick_total: 64'd0};
        end else begin
            if (i_cfg_valid) begin
                r_run_enable <= i_cfg_data;
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    `ASSERT_CLKD(a_hundredth_range, (r_state.hundredth_count <= bcc_pkg::C_HUNDREDTH_MAX), "hundredth counter out of range")
    `ASSERT_CLKD(a_day_nonzero, (r_state.day_count != 5'd0), "day counter is zero")
    `ASSERT_CLKD(a_tick_counts, (w_move && (r_in.mode == bcc_pkg::MODE_TICK) && r_run_enable) |=> (r_state.tick_total == $past(r_state.tick_total) + 64'd1), "enabled tick did not advance the tick count")
    `ASSERT_CLKD(a_load_clears, (w_move && (r_in.mode == bcc_pkg::MODE_LOAD)) |=> (r_state.hundredth_count == 7'd0), "load did not clear the hundredths")
    `ASSERT_CLKD(a_stall_holds_state, (!w_move) |=> $stable(r_state), "calendar changed without a request")

endmodule
